[hdl/assert_macros.svh]
// Assertion macros shared by the downsampler RTL.
// Uses the clk and rst names of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

[hdl/bad_pkg.sv]
// Shared types, constants and block-placement helper for the box average downsampler.
// No dependencies; used by bad_div and box_average_downsampler.
`default_nettype none

package bad_pkg;

  localparam int PIX_W       = 8;
  localparam int DIM_W       = 13;
  localparam int SUM_W       = 14;
  localparam int RS_W        = 11;
  localparam int D_W         = 7;
  localparam int SIZE_W      = 4;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 14;
  localparam int MAX_ROWS    = 4096;

  localparam logic [1:0]       FACTOR_RST = 2'd1;
  localparam logic [DIM_W-1:0] COLS_RST   = 13'd640;
  localparam logic [DIM_W-1:0] ROWS_RST   = 13'd480;

  typedef enum logic [1:0] {
    REG_FACTOR = 2'd0,
    REG_COLS   = 2'd1,
    REG_ROWS   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              covered;
    logic              at_end;
    logic              is_last;
    logic              first;
    logic [DIM_W-1:0]  index;
    logic [SIZE_W-1:0] size;
  } span_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SUM_W-1:0] total;
    logic [D_W-1:0]   d;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [PIX_W-1:0] avg;
  } div_res_t;

  // floor(2^14 / d) for d = 1..64, indexed by d-1
  localparam logic [RECIP_W-1:0] RECIP [64] = '{
    15'd16384, 15'd8192, 15'd5461, 15'd4096, 15'd3276, 15'd2730, 15'd2340, 15'd2048,
    15'd1820,  15'd1638, 15'd1489, 15'd1365, 15'd1260, 15'd1170, 15'd1092, 15'd1024,
    15'd963,   15'd910,  15'd862,  15'd819,  15'd780,  15'd744,  15'd712,  15'd682,
    15'd655,   15'd630,  15'd606,  15'd585,  15'd564,  15'd546,  15'd528,  15'd512,
    15'd496,   15'd481,  15'd468,  15'd455,  15'd442,  15'd431,  15'd420,  15'd409,
    15'd399,   15'd390,  15'd381,  15'd372,  15'd364,  15'd356,  15'd348,  15'd341,
    15'd334,   15'd327,  15'd321,  15'd315,  15'd309,  15'd303,  15'd297,  15'd292,
    15'd287,   15'd282,  15'd277,  15'd273,  15'd268,  15'd264,  15'd260,  15'd256
  };

  // Places a position of a dimension of length n into its block, block size 1 << k.
  // The last block starts on the full-block grid and is n mod f wide (f if zero).
  function automatic span_t locate(logic [DIM_W-1:0] pos, logic [DIM_W-1:0] n,
                                   logic [1:0] k);
    logic [SIZE_W-1:0] f;
    logic [DIM_W-1:0]  mask;
    logic [DIM_W-1:0]  out_n;
    logic [DIM_W-1:0]  rem;
    logic [DIM_W-1:0]  idx;
    logic [DIM_W-1:0]  off;
    span_t             s;
    f     = 4'd1 << k;
    mask  = 13'(f) - 13'd1;
    out_n = n >> k;
    if (out_n == '0) out_n = 13'd1;
    rem   = n & mask;
    if (rem == '0) rem = 13'(f);
    idx   = pos >> k;
    off   = pos & mask;
    s.covered = 1'b0;
    s.at_end  = 1'b0;
    s.is_last = 1'b0;
    s.first   = (off == '0);
    s.index   = idx;
    s.size    = f;
    if (idx + 13'd1 < out_n) begin
      s.covered = 1'b1;
      s.at_end  = (off == mask);
    end else if (idx + 13'd1 == out_n && off < rem) begin
      s.covered = 1'b1;
      s.is_last = 1'b1;
      s.size    = rem[SIZE_W-1:0];
      s.at_end  = (off == rem - 13'd1);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/bad_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bad_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/bad_div.sv]
// Three-stage divider of a block sum by the block's pixel count (1..64).
// Reciprocal table from bad_pkg, estimate, then one correction step.
`default_nettype none

`include "assert_macros.svh"

module bad_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  bad_pkg::div_req_t req,
  output bad_pkg::div_res_t res
);

  logic                              s1_valid;
  logic                              s1_last;
  logic [bad_pkg::SUM_W-1:0]         s1_total;
  logic [bad_pkg::D_W-1:0]           s1_d;
  logic [bad_pkg::RECIP_W-1:0]       s1_recip;
  logic                              s2_valid;
  logic                              s2_last;
  logic [bad_pkg::SUM_W-1:0]         s2_total;
  logic [bad_pkg::D_W-1:0]           s2_d;
  logic [bad_pkg::PIX_W-1:0]         s2_q0;
  logic                              r_valid;
  logic                              r_last;
  logic [bad_pkg::PIX_W-1:0]         r_avg;
  logic [5:0]                        ridx;
  logic [28:0]                       prod;
  logic [14:0]                       back;
  logic [14:0]                       rem;
  logic                              fix;

  assign ridx = 6'(req.d - 7'd1);
  assign prod = 29'(s1_total) * 29'(s1_recip);
  // estimate is low by at most one
  assign back = 15'(s2_q0) * 15'(s2_d);
  assign rem  = 15'(s2_total) - back;
  assign fix  = (rem >= 15'(s2_d));
  assign res  = {r_valid, r_last, r_avg};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      r_valid  <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      r_valid  <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last  <= req.last;
      s1_total <= req.total;
      s1_d     <= req.d;
      s1_recip <= bad_pkg::RECIP[ridx];
      s2_last  <= s1_last;
      s2_total <= s1_total;
      s2_d     <= s1_d;
      s2_q0    <= prod[bad_pkg::RECIP_SHIFT +: bad_pkg::PIX_W];
      r_last   <= s2_last;
      r_avg    <= fix ? s2_q0 + 8'd1 : s2_q0;
    end
  end

  `ASSERT_IMP(a_div_estimate, s2_valid, rem < (15'(s2_d) << 1), "quotient estimate off by more than one")

endmodule

`default_nettype wire

[hdl/box_average_downsampler.sv]
// Box average downsampler top level: position tracking, column-sum store, output skid.
// Depends on bad_pkg, bad_ram, bad_div and assert_macros.svh.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_ready with pixel_in. Each request
//   completing a block yields one result on out_valid/out_ready carrying avg_pixel
//   (truncated block mean) and frame_last on the frame's final output pixel.
//   With factor 1 every pixel is passed through as a result.
//   Throughput: one pixel per clock while in_ready is high. The column-sum RAM is
//   read as a pixel closes a block's column span and written back, with forwarding,
//   from the stage after accept. The request completing a block passes that stage,
//   divider reciprocal, estimate and correction registers, and the output register.
//   The column-sum store needs no clearing: the first row of every block row
//   ignores the stored value, so the block is ready right after reset.
//   Reset (rst, synchronous) restores factor 2, 640 x 480 and restarts the frame.
//   A configuration write (cfg_we, cfg_index, cfg_data) to a known register also
//   restarts the frame; write only while idle.
//   When the receiver stalls, one more result is kept in a skid register;
//   in_ready drops only while that register is occupied or rst is high.
`default_nettype none

`include "assert_macros.svh"

module box_average_downsampler #(
  parameter int MAX_COLS   = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  avg_pixel,
  output logic        frame_last
);

  localparam int SUM_DEPTH = MAX_COLS / 2;
  localparam int AW        = $clog2(SUM_DEPTH);
  localparam int MAX_K     = (MAX_FACTOR >= 8) ? 3 : ((MAX_FACTOR >= 4) ? 2 : 1);
  localparam int COL_LIM   = (MAX_COLS > 8191) ? 8191 : MAX_COLS;

  // configuration and position
  logic [1:0]                  factor_log2;
  logic [12:0]                 image_cols;
  logic [12:0]                 image_rows;
  logic [12:0]                 in_col;
  logic [11:0]                 in_row;
  logic [bad_pkg::RS_W-1:0]    row_sum;

  logic [1:0]                  k;
  logic [12:0]                 cols;
  logic [12:0]                 rows;
  logic [12:0]                 col_inc;
  logic [12:0]                 row_inc;
  logic                        col_wrap;
  logic                        row_wrap;
  bad_pkg::span_t              cspan;
  bad_pkg::span_t              rspan;
  logic                        in_blk;
  logic                        acc;
  logic                        hit;
  logic                        re;
  logic [AW-1:0]               rd_addr;
  logic [bad_pkg::RS_W-1:0]    rs_sum;
  logic                        cfg_restart;
  logic                        adv;

  // stage after accept
  logic                        b_mem;
  logic                        b_res;
  logic                        b_first;
  logic                        b_bypass;
  logic                        b_last;
  logic [AW-1:0]               b_addr;
  logic [bad_pkg::RS_W-1:0]    b_rowsum;
  logic [7:0]                  b_px;
  logic [bad_pkg::D_W-1:0]     b_d;

  logic [bad_pkg::SUM_W-1:0]   rdata;
  logic [bad_pkg::SUM_W-1:0]   col_old;
  logic [bad_pkg::SUM_W-1:0]   total;
  logic                        we;
  logic                        fwd_hit;
  logic [bad_pkg::SUM_W-1:0]   fwd_data;

  bad_pkg::div_req_t           dreq;
  bad_pkg::div_res_t           dres;

  logic                        skid_valid;
  logic [7:0]                  skid_avg;
  logic                        skid_last;

  always_comb begin
    k = (factor_log2 > 2'(MAX_K)) ? 2'(MAX_K) : factor_log2;
    if (image_cols == '0)                 cols = 13'd1;
    else if (image_cols > 13'(COL_LIM))   cols = 13'(COL_LIM);
    else                                  cols = image_cols;
    if (image_rows == '0)                         rows = 13'd1;
    else if (image_rows > 13'(bad_pkg::MAX_ROWS)) rows = 13'(bad_pkg::MAX_ROWS);
    else                                          rows = image_rows;
  end

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        bad_pkg::REG_FACTOR,
        bad_pkg::REG_COLS,
        bad_pkg::REG_ROWS:   cfg_restart = 1'b1;
        default:             cfg_restart = 1'b0;
      endcase
    end
  end

  assign adv      = !skid_valid;
  assign in_ready = adv && !rst;
  assign acc      = in_valid && in_ready;

  assign col_inc  = in_col + 13'd1;
  assign row_inc  = 13'(in_row) + 13'd1;
  assign col_wrap = (col_inc >= cols);
  assign row_wrap = (row_inc >= rows);

  assign cspan   = bad_pkg::locate(in_col, cols, k);
  assign rspan   = bad_pkg::locate(13'(in_row), rows, k);
  assign in_blk  = cspan.covered && rspan.covered && ({1'b0, cspan.index} < 14'(SUM_DEPTH));
  assign hit     = acc && (k != 2'd0) && in_blk;
  assign re      = hit && cspan.at_end;
  assign rd_addr = cspan.index[AW-1:0];
  assign rs_sum  = row_sum + {3'b000, pixel_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_log2 <= bad_pkg::FACTOR_RST;
      image_cols  <= bad_pkg::COLS_RST;
      image_rows  <= bad_pkg::ROWS_RST;
      in_col      <= '0;
      in_row      <= '0;
      row_sum     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bad_pkg::REG_FACTOR: factor_log2 <= cfg_data[1:0];
          bad_pkg::REG_COLS:   image_cols  <= cfg_data;
          bad_pkg::REG_ROWS:   image_rows  <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_restart) begin
        in_col  <= '0;
        in_row  <= '0;
        row_sum <= '0;
      end else if (acc) begin
        if (col_wrap) begin
          in_col <= '0;
          in_row <= row_wrap ? 12'd0 : row_inc[11:0];
        end else begin
          in_col <= col_inc;
        end
        if (hit) row_sum <= cspan.at_end ? '0 : rs_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_mem    <= 1'b0;
      b_bypass <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      b_mem    <= re;
      b_bypass <= acc && (k == 2'd0);
      // the write issued now lands too late for a read of the same entry issued now
      fwd_hit  <= re && we && (rd_addr == b_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_res    <= rspan.at_end;
      b_first  <= rspan.first;
      b_last   <= (k == 2'd0) ? (col_wrap && row_wrap) : (cspan.is_last && rspan.is_last);
      b_addr   <= rd_addr;
      b_rowsum <= rs_sum;
      b_px     <= pixel_in;
      b_d      <= 7'({3'b000, cspan.size} * {3'b000, rspan.size});
      fwd_data <= total;
    end
  end

  // first row of a block row starts from zero, whatever the store holds
  assign col_old = b_first ? '0 : (fwd_hit ? fwd_data : rdata);
  assign total   = col_old + {3'b000, b_rowsum};
  assign we      = adv && b_mem;

  bad_ram #(
    .WIDTH (bad_pkg::SUM_W),
    .DEPTH (SUM_DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (we),
    .waddr (b_addr),
    .wdata (total),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    dreq.valid = b_bypass || (b_mem && b_res);
    dreq.last  = b_last;
    dreq.total = b_bypass ? {6'b000000, b_px} : total;
    dreq.d     = b_bypass ? 7'd1 : b_d;
  end

  bad_div u_div (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .req (dreq),
    .res (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (adv) begin
      if (dres.valid) begin
        if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (out_ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dres.valid) begin
        if (!out_valid || out_ready) begin
          avg_pixel  <= dres.avg;
          frame_last <= dres.last;
        end else begin
          skid_avg  <= dres.avg;
          skid_last <= dres.last;
        end
      end
    end else if (out_ready) begin
      avg_pixel  <= skid_avg;
      frame_last <= skid_last;
    end
  end

  `ASSERT_IMP(a_skid_out, skid_valid, out_valid, "skid holds a result while output is empty")
  `ASSERT_ALWAYS(a_col_range, in_col < cols, "column position beyond image width")
  `ASSERT_ALWAYS(a_row_range, 13'(in_row) < rows, "row position beyond image height")
  `ASSERT_IMP(a_fwd_mem, fwd_hit, b_mem, "forwarded sum without a pending column update")

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for box_average_downsampler: streams pixel frames under random flow control
// and checks each block mean and frame marker against a predictor kept in the bench.
// Depends on bad_pkg and the downsampler RTL.
module tb;

  localparam int         SUM_ENTRIES   = 2048;
  localparam int         DRAIN_CYCLES  = 8;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         RANDOM_PIXELS = 450;
  localparam logic [1:0] REG_SPARE     = 2'd3;  // unmapped index, must not restart the frame

  typedef struct packed {
    logic [7:0] avg;
    logic       last;
  } block_mean_t;

  typedef struct packed {
    logic        hit;
    logic        closes;
    logic        tail_blk;
    logic [12:0] idx;
    logic [3:0]  span;
  } block_pos_t;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREME} fill_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = bad_pkg::REG_FACTOR;
  logic [12:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_in  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  avg_pixel;
  logic        frame_last;

  // predictor state
  logic [13:0] col_sums [SUM_ENTRIES];
  logic [12:0] cur_col, cur_row;
  logic [10:0] run_sum;
  logic [1:0]  shift_cfg;
  logic [12:0] cols_cfg, rows_cfg;
  block_mean_t means_q [$];
  int          mismatches = 0;

  // flow control state
  int          burst_left  = 0;
  int          hold_ask    = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  logic [15:0] rx_cycle    = '0;
  int          idle_cycles = 0;

  box_average_downsampler uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .avg_pixel  (avg_pixel),
    .frame_last (frame_last)
  );

  always #5 clk = ~clk;

  function automatic logic [12:0] clamp_len(logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  // Block that a position falls in; the last block sits on the full grid
  // and only covers len mod f (f if that is zero).
  function automatic block_pos_t find_block(logic [12:0] pos, logic [12:0] len,
                                            logic [1:0] sh);
    logic [12:0] fsz, nblk, tail, off;
    block_pos_t  b;
    fsz  = 13'd1 << sh;
    nblk = len >> sh;
    if (nblk == 13'd0) nblk = 13'd1;
    tail = len & (fsz - 13'd1);
    if (tail == 13'd0) tail = fsz;
    off    = pos & (fsz - 13'd1);
    b      = '0;
    b.idx  = pos >> sh;
    b.span = fsz[3:0];
    if (b.idx + 13'd1 < nblk) begin
      b.hit    = 1'b1;
      b.closes = (off == fsz - 13'd1);
    end else if (b.idx + 13'd1 == nblk && off < tail) begin
      b.hit      = 1'b1;
      b.tail_blk = 1'b1;
      b.span     = tail[3:0];
      b.closes   = (off == tail - 13'd1);
    end
    return b;
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < SUM_ENTRIES; i++) col_sums[i] = '0;
    cur_col = '0;
    cur_row = '0;
    run_sum = '0;
  endtask

  task automatic account_pixel(logic [7:0] px);
    logic [12:0] ncols, nrows;
    block_pos_t  cpos, rpos;
    block_mean_t m;
    int          total;
    ncols = clamp_len(cols_cfg);
    nrows = clamp_len(rows_cfg);
    if (shift_cfg == 2'd0) begin
      m.avg  = px;
      m.last = (int'(cur_col) + 1 >= int'(ncols)) && (int'(cur_row) + 1 >= int'(nrows));
      means_q.push_back(m);
    end else begin
      cpos = find_block(cur_col, ncols, shift_cfg);
      rpos = find_block(cur_row, nrows, shift_cfg);
      if (cpos.hit && rpos.hit && cpos.idx < SUM_ENTRIES) begin
        run_sum = run_sum + {3'b000, px};
        if (cpos.closes) begin
          total   = int'(col_sums[cpos.idx]) + int'(run_sum);
          run_sum = '0;
          if (rpos.closes) begin
            m.avg  = 8'(total / (int'(cpos.span) * int'(rpos.span)));
            m.last = cpos.tail_blk && rpos.tail_blk;
            means_q.push_back(m);
            col_sums[cpos.idx] = '0;
          end else begin
            col_sums[cpos.idx] = 14'(total);
          end
        end
      end
    end
    cur_col = cur_col + 13'd1;
    if (cur_col >= ncols) begin
      cur_col = '0;
      cur_row = cur_row + 13'd1;
      if (cur_row >= nrows) cur_row = '0;
    end
  endtask

  // Only called while idle; every known register restarts the frame.
  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == bad_pkg::REG_FACTOR) shift_cfg = val[1:0];
    else if (idx == bad_pkg::REG_COLS) cols_cfg = val;
    else if (idx == bad_pkg::REG_ROWS) rows_cfg = val;
    if (idx != REG_SPARE) restart_frame();
  endtask

  task automatic send_pixel(logic [7:0] px);
    logic took;
    in_valid <= 1'b1;
    pixel_in <= px;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    account_pixel(px);
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (means_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel(fill_t f);
    case (f)
      FILL_WHITE:   return 8'hFF;
      FILL_BLACK:   return 8'h00;
      FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [12:0] pick_len();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_run(int count, fill_t f, bit paced);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_pixel(f));
      if (paced) pace();
    end
  endtask

  // factor 2 over 640 x 480 after reset: a couple of pixels complete nothing
  task automatic test_reset_state();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    settle();
  endtask

  task automatic test_pass_through();
    logic [7:0] vals [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
    write_reg(bad_pkg::REG_FACTOR, 13'd0);
    write_reg(bad_pkg::REG_COLS, 13'd3);
    write_reg(bad_pkg::REG_ROWS, 13'd2);
    foreach (vals[i]) begin
      send_pixel(vals[i]);
      pace();
    end
    settle();
  endtask

  // 5 x 3 at factor 2: last block column is one pixel wide, columns 3..4 and
  // rows 1..2 fall outside every block and are swallowed.
  task automatic test_partial_blocks();
    write_reg(bad_pkg::REG_FACTOR, 13'd1);
    write_reg(bad_pkg::REG_COLS, 13'd5);
    write_reg(bad_pkg::REG_ROWS, 13'd3);
    send_run(15, FILL_RANDOM, 1'b1);
    settle();
  endtask

  // zero dims act as 1, oversize width saturates
  task automatic test_degenerate_dims();
    write_reg(bad_pkg::REG_FACTOR, 13'd0);
    write_reg(bad_pkg::REG_COLS, 13'd0);
    write_reg(bad_pkg::REG_ROWS, 13'd0);
    send_run(2, FILL_RANDOM, 1'b1);
    settle();
    write_reg(bad_pkg::REG_COLS, 13'd8191);
    write_reg(bad_pkg::REG_ROWS, 13'd1);
    send_run(2, FILL_RANDOM, 1'b1);
    settle();
  endtask

  task automatic test_spare_register();
    write_reg(bad_pkg::REG_FACTOR, 13'd0);
    write_reg(bad_pkg::REG_COLS, 13'd2);
    write_reg(bad_pkg::REG_ROWS, 13'd2);
    send_pixel(8'h3C);
    settle();
    write_reg(REG_SPARE, 13'($urandom));
    send_run(3, FILL_RANDOM, 1'b1);
    settle();
  endtask

  // Receiver holds off while requests keep coming back to back, so the skid
  // fills and in_ready drops; then the sender waits for a full drain.
  task automatic test_backpressure();
    write_reg(bad_pkg::REG_FACTOR, 13'd0);
    write_reg(bad_pkg::REG_COLS, 13'd16);
    write_reg(bad_pkg::REG_ROWS, 13'd4);
    hold_ask <= hold_ask + 1;
    send_run(64, FILL_RANDOM, 1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int    pixels_sent;
    int    frame_px;
    int    n;
    fill_t fill;
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) != 0) write_reg(bad_pkg::REG_FACTOR, 13'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) write_reg(bad_pkg::REG_COLS, pick_len());
      if ($urandom_range(0, 3) != 0) write_reg(bad_pkg::REG_ROWS, pick_len());
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 13'($urandom));
      fill = ($urandom_range(0, 2) != 0) ? FILL_RANDOM : fill_t'($urandom_range(1, 3));
      frame_px = int'(clamp_len(cols_cfg)) * int'(clamp_len(rows_cfg));
      // mostly whole frames; huge sizes and some broken frames stop early
      if (frame_px > 300 || $urandom_range(0, 5) == 0)
        n = $urandom_range(1, (frame_px < 40) ? frame_px : 40);
      else
        n = frame_px * $urandom_range(1, 2);
      if (n > RANDOM_PIXELS - pixels_sent) n = RANDOM_PIXELS - pixels_sent;
      send_run(n, fill, 1'b1);
      pixels_sent += n;
      settle();
    end
  endtask

  // receiver: stall pattern follows rx_cycle[8:6], plus requested long holds
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1: out_ready <= 1'b1;
        3'd2, 3'd3: out_ready <= ($urandom_range(0, 1) != 0);
        3'd4:       out_ready <= ($urandom_range(0, 3) == 0);
        3'd5:       out_ready <= (rx_cycle[2:0] != 3'd0);
        3'd6:       out_ready <= rx_cycle[3];
        default:    out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // outputs settle right after the rising edge, so sample at the falling one
  always @(negedge clk) begin
    block_mean_t want;
    if (!rst && out_valid && out_ready) begin
      if (means_q.size() == 0) begin
        $display("%0t: unexpected result avg_pixel %0d frame_last %0d",
                 $time, avg_pixel, frame_last);
        mismatches++;
      end else begin
        want = means_q.pop_front();
        if (avg_pixel !== want.avg) begin
          $display("%0t: avg_pixel expected %0d, got %0d", $time, want.avg, avg_pixel);
          mismatches++;
        end
        if (frame_last !== want.last) begin
          $display("%0t: frame_last expected %0d, got %0d", $time, want.last, frame_last);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, means_q.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    shift_cfg = bad_pkg::FACTOR_RST;
    cols_cfg  = bad_pkg::COLS_RST;
    rows_cfg  = bad_pkg::ROWS_RST;
    restart_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_pass_through();
    test_partial_blocks();
    test_degenerate_dims();
    test_spare_register();
    test_backpressure();
    test_random_frames();
    settle();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/bad_pkg.sv
hdl/bad_ram.sv
hdl/bad_div.sv
hdl/box_average_downsampler.sv
test/tb.sv
